[rtl/core/ecmu_pkg.sv]
`default_nettype none
package ecmu_pkg;

	typedef enum logic [2:0] {
		CMD_SET_CONTEXT = 3'd0,
		CMD_OPEN        = 3'd1,
		CMD_APPEND      = 3'd2,
		CMD_CLOSE       = 3'd3,
		CMD_BLOCK       = 3'd4,
		CMD_READ        = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		ST_DONE     = 3'd0,
		ST_IGNORED  = 3'd1,
		ST_NO_HIT   = 3'd2,
		ST_REJECTED = 3'd3,
		ST_FULL     = 3'd4,
		ST_REPEAT   = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SEARCH,
		S_MAP_RD,
		S_MAP_WR,
		S_OUT
	} state_t;

	localparam int unsigned LANES = 8;

	function automatic logic [31:0] edge_hash(input logic [31:0] hash, input logic [31:0] off);
		edge_hash = hash ^ (off >> 4) ^ (off << 8);
	endfunction

endpackage
`default_nettype wire

[rtl/core/edge_coverage_map_update_core.sv]
// result path: table commands and blocks dropped, repeated or meeting an empty table are
// answered on acceptance; a map read passes S_MAP_RD and S_MAP_WR; a searched block has a read
// and a compare phase per row of eight regions, then the map update; a miss scans each filled row
// throughput: one transfer in flight; the next is taken the cycle after the result transfer
// reset: control state clears and a pass writes zero to every map entry before the first
// transfer is taken
`default_nettype none
module edge_coverage_map_update_core import ecmu_pkg::*; #(
	parameter int unsigned MAP_ENTRIES    = 65536,
	parameter int unsigned REGION_ENTRIES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  command,
	input  wire logic [31:0] region_start,
	input  wire logic [31:0] region_end,
	input  wire logic [31:0] name_hash,
	input  wire logic        ignore_task,
	input  wire logic [31:0] block_start,
	input  wire logic [15:0] block_size,
	input  wire logic        privileged,
	input  wire logic [15:0] read_index,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [15:0]      map_index,
	output logic [7:0]       count
);

	localparam int unsigned MW = $clog2(MAP_ENTRIES);
	localparam int unsigned LW = $clog2(LANES);
	localparam int unsigned AW = ($clog2(REGION_ENTRIES) > LW) ? $clog2(REGION_ENTRIES) : LW;
	localparam int unsigned CW = $clog2(REGION_ENTRIES + 1);
	localparam int unsigned NB = (REGION_ENTRIES + LANES - 1) / LANES;
	localparam int unsigned BW = (NB > 1) ? $clog2(NB) : 1;

	state_t state_q, state_d;

	logic [CW-1:0] region_count_q;
	logic          table_open_q;
	logic          context_valid_q;
	logic          task_ignored_q;
	logic [31:0]   prev_q;
	logic [31:0]   last_lo_q;
	logic [31:0]   last_hi_q;
	logic [MW-1:0] clr_q;
	logic [31:0]   start_q;
	logic [BW:0]   blk_q;
	logic          rd_phase_q;
	logic          is_read_q;
	logic [MW-1:0] idx_q;
	logic [2:0]    status_q;
	logic [15:0]   map_index_q;
	logic [7:0]    count_q;
	logic          out_valid_q;

	// region table: eight banks searched in parallel
	logic [LANES-1:0] tb_we;
	logic [31:0] tb_lo [LANES];
	logic [31:0] tb_hi [LANES];
	logic [31:0] tb_hash [LANES];
	logic [BW-1:0] tb_raddr;
	logic [BW-1:0] tb_waddr;
	logic [AW-1:0] app_addr;

	assign app_addr = AW'(region_count_q);

	genvar g;
	generate
		for (g = 0; g < LANES; g++) begin : g_bank
			ecmu_region_table #(.REGION_ENTRIES(NB), .AW(BW)) u_bank (
				.clk     (clk),
				.wr_en   (tb_we[g]),
				.wr_addr (tb_waddr),
				.wr_lo   (region_start),
				.wr_hi   (region_end),
				.wr_hash (name_hash),
				.rd_addr (tb_raddr),
				.rd_lo   (tb_lo[g]),
				.rd_hi   (tb_hi[g]),
				.rd_hash (tb_hash[g])
			);
		end
	endgenerate

	logic [MW-1:0] mp_waddr, mp_raddr;
	logic [7:0] mp_wdata, mp_rdata;
	logic mp_we;

	ecmu_hit_map #(.MAP_ENTRIES(MAP_ENTRIES), .MW(MW)) u_map (
		.clk     (clk),
		.wr_en   (mp_we),
		.wr_addr (mp_waddr),
		.wr_data (mp_wdata),
		.rd_addr (mp_raddr),
		.rd_data (mp_rdata)
	);

	logic accept;
	assign in_stall = (state_q != S_IDLE) || out_valid_q;
	assign accept   = in_valid && !in_stall;

	// search hit over the current bank row
	logic          hit;
	logic [LW-1:0] hit_lane;
	logic [31:0]   hit_cur;
	always_comb begin
		logic [CW+LW:0] ent;
		hit      = 1'b0;
		hit_lane = '0;
		for (int l = LANES - 1; l >= 0; l--) begin
			ent = (CW+LW+1)'(blk_q) * (CW+LW+1)'(LANES) + (CW+LW+1)'(l);
			if (ent < (CW+LW+1)'(region_count_q) && start_q >= tb_lo[l] && start_q < tb_hi[l]) begin
				hit      = 1'b1;
				hit_lane = LW'(l);
			end
		end
		hit_cur = edge_hash(tb_hash[hit_lane], start_q - tb_lo[hit_lane]);
	end

	logic last_blk;
	assign last_blk = (blk_q + 1'b1) * LANES >= region_count_q;

	always_comb begin
		tb_we    = '0;
		tb_waddr = BW'(app_addr >> LW);
		tb_raddr = blk_q[BW-1:0];
		if (accept && command == CMD_APPEND && context_valid_q && table_open_q &&
				region_count_q < CW'(REGION_ENTRIES)) begin
			tb_we[app_addr[LW-1:0]] = 1'b1;
		end
		mp_raddr = idx_q;
		mp_we    = 1'b0;
		mp_waddr = idx_q;
		mp_wdata = mp_rdata + 8'd1;
		if (state_q == S_CLEAR) begin
			mp_we    = 1'b1;
			mp_waddr = clr_q;
			mp_wdata = '0;
		end else if (state_q == S_MAP_WR && !is_read_q) begin
			mp_we = 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR:  if (clr_q == MW'(MAP_ENTRIES - 1)) state_d = S_IDLE;
			S_IDLE:   if (accept) begin
				if (command == CMD_READ) state_d = S_MAP_RD;
				else if (command == CMD_BLOCK && !privileged && context_valid_q &&
						!task_ignored_q && !(block_start >= last_lo_q && block_start < last_hi_q) &&
						region_count_q != '0) state_d = S_SEARCH;
			end
			S_SEARCH: if (rd_phase_q) begin
				if (hit) state_d = S_MAP_RD;
				else if (last_blk) state_d = S_IDLE;
			end
			S_MAP_RD: state_d = S_MAP_WR;
			S_MAP_WR: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_CLEAR;
			clr_q           <= '0;
			region_count_q  <= '0;
			table_open_q    <= 1'b0;
			context_valid_q <= 1'b0;
			task_ignored_q  <= 1'b0;
			prev_q          <= '0;
			last_lo_q       <= '0;
			last_hi_q       <= '0;
			out_valid_q     <= 1'b0;
			blk_q           <= '0;
			rd_phase_q      <= 1'b0;
			is_read_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			if (accept) begin
				status_q    <= ST_DONE;
				map_index_q <= '0;
				count_q     <= '0;
				start_q     <= block_start;
				blk_q       <= '0;
				rd_phase_q  <= 1'b0;
				is_read_q   <= (command == CMD_READ);
				idx_q       <= MW'(read_index);
				out_valid_q <= 1'b1;
				case (command)
					CMD_SET_CONTEXT: begin
						context_valid_q <= 1'b1;
						task_ignored_q  <= ignore_task;
						prev_q          <= name_hash;
						last_lo_q       <= '0;
						last_hi_q       <= '0;
					end
					CMD_OPEN: begin
						if (!context_valid_q || table_open_q) status_q <= ST_REJECTED;
						else begin
							table_open_q   <= 1'b1;
							region_count_q <= '0;
						end
					end
					CMD_APPEND: begin
						if (!context_valid_q || !table_open_q) status_q <= ST_REJECTED;
						else if (region_count_q >= CW'(REGION_ENTRIES)) status_q <= ST_FULL;
						else region_count_q <= region_count_q + 1'b1;
					end
					CMD_CLOSE: begin
						if (!context_valid_q || !table_open_q) status_q <= ST_REJECTED;
						else table_open_q <= 1'b0;
					end
					CMD_BLOCK: begin
						if (privileged || !context_valid_q || task_ignored_q) status_q <= ST_IGNORED;
						else if (block_start >= last_lo_q && block_start < last_hi_q)
							status_q <= ST_REPEAT;
						else begin
							last_lo_q <= block_start;
							last_hi_q <= block_start + 32'(block_size);
							if (region_count_q != '0) out_valid_q <= 1'b0;
							else status_q <= ST_NO_HIT;
						end
					end
					CMD_READ: out_valid_q <= 1'b0;
					default: status_q <= ST_REJECTED;
				endcase
			end
			if (state_q == S_SEARCH) begin
				rd_phase_q <= !rd_phase_q;
				if (rd_phase_q) begin
					if (hit) begin
						idx_q  <= MW'(hit_cur ^ prev_q);
						prev_q <= hit_cur >> 1;
					end else begin
						blk_q <= blk_q + 1'b1;
						if (last_blk) begin
							status_q    <= ST_NO_HIT;
							out_valid_q <= 1'b1;
						end
					end
				end
			end
			if (state_q == S_MAP_WR) begin
				status_q    <= ST_DONE;
				map_index_q <= 16'(idx_q);
				count_q     <= is_read_q ? mp_rdata : mp_rdata + 8'd1;
				out_valid_q <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign map_index = map_index_q;
	assign count     = count_q;

endmodule
`default_nettype wire

[rtl/core/ecmu_region_table.sv]
`default_nettype none
module ecmu_region_table import ecmu_pkg::*; #(
	parameter int unsigned REGION_ENTRIES = 64,
	parameter int unsigned AW = (REGION_ENTRIES > 1) ? $clog2(REGION_ENTRIES) : 1
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [31:0]   wr_lo,
	input  wire logic [31:0]   wr_hi,
	input  wire logic [31:0]   wr_hash,
	input  wire logic [AW-1:0] rd_addr,
	output logic [31:0]        rd_lo,
	output logic [31:0]        rd_hi,
	output logic [31:0]        rd_hash
);

	logic [95:0] mem [REGION_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_lo, wr_hi, wr_hash};
		end
		{rd_lo, rd_hi, rd_hash} <= mem[rd_addr];
	end

endmodule
`default_nettype wire

[rtl/core/ecmu_hit_map.sv]
`default_nettype none
module ecmu_hit_map #(
	parameter int unsigned MAP_ENTRIES = 65536,
	parameter int unsigned MW = $clog2(MAP_ENTRIES)
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [MW-1:0] wr_addr,
	input  wire logic [7:0]    wr_data,
	input  wire logic [MW-1:0] rd_addr,
	output logic [7:0]         rd_data
);

	logic [7:0] mem [MAP_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

[tb/tb_edge_coverage_map_update_core.sv]
`timescale 1ns / 1ps
`default_nettype none
module tb_edge_coverage_map_update_core;
	import ecmu_pkg::*;

	localparam int unsigned MAP_N = 65536;
	localparam int unsigned REG_N = 64;

	typedef struct packed {
		status_t     st;
		logic [15:0] idx;
		logic [7:0]  cnt;
	} edge_result_t;

	class coverage_scoreboard;
		logic [7:0]  hits [MAP_N];
		logic [31:0] lo_tab [REG_N];
		logic [31:0] hi_tab [REG_N];
		logic [31:0] hash_tab [REG_N];
		int unsigned n_regions;
		bit          is_open;
		bit          ctx_set;
		bit          ctx_ignored;
		logic [31:0] prev_loc;
		logic [31:0] last_start;
		logic [31:0] last_stop;
		edge_result_t pending [$];
		int          errors;

		function void init();
			foreach (hits[i]) hits[i] = '0;
			n_regions = 0;
			is_open = 0;
			ctx_set = 0;
			ctx_ignored = 0;
			prev_loc = '0;
			last_start = '0;
			last_stop = '0;
			errors = 0;
		endfunction

		function void note_transfer(logic [2:0] cmd, logic [31:0] rs, logic [31:0] re,
				logic [31:0] nh, logic ign, logic [31:0] bs, logic [15:0] bsz,
				logic priv, logic [15:0] ridx);
			edge_result_t r;
			logic [31:0] off, cur, ix;
			bit found;
			r.st = ST_DONE;
			r.idx = '0;
			r.cnt = '0;
			case (cmd)
				CMD_SET_CONTEXT: begin
					ctx_set = 1;
					ctx_ignored = ign;
					prev_loc = nh;
					last_start = '0;
					last_stop = '0;
				end
				CMD_OPEN: begin
					if (!ctx_set || is_open) r.st = ST_REJECTED;
					else begin
						is_open = 1;
						n_regions = 0;
					end
				end
				CMD_APPEND: begin
					if (!ctx_set || !is_open) r.st = ST_REJECTED;
					else if (n_regions >= REG_N) r.st = ST_FULL;
					else begin
						lo_tab[n_regions] = rs;
						hi_tab[n_regions] = re;
						hash_tab[n_regions] = nh;
						n_regions++;
					end
				end
				CMD_CLOSE: begin
					if (!ctx_set || !is_open) r.st = ST_REJECTED;
					else is_open = 0;
				end
				CMD_BLOCK: begin
					if (priv || !ctx_set || ctx_ignored) r.st = ST_IGNORED;
					else if (bs >= last_start && bs < last_stop) r.st = ST_REPEAT;
					else begin
						last_start = bs;
						last_stop = bs + {16'h0, bsz};
						found = 0;
						for (int i = 0; i < n_regions; i++) begin
							if (!found && bs >= lo_tab[i] && bs < hi_tab[i]) begin
								found = 1;
								off = bs - lo_tab[i];
								cur = hash_tab[i] ^ (off >> 4) ^ (off << 8);
								ix = (cur ^ prev_loc) % MAP_N;
								hits[ix] = hits[ix] + 8'd1;
								prev_loc = cur >> 1;
								r.idx = ix[15:0];
								r.cnt = hits[ix];
							end
						end
						if (!found) r.st = ST_NO_HIT;
					end
				end
				CMD_READ: begin
					ix = {16'h0, ridx} % MAP_N;
					r.idx = ix[15:0];
					r.cnt = hits[ix];
				end
				default: r.st = ST_REJECTED;
			endcase
			pending.insert(pending.size(), r);
		endfunction

		function void check_result(logic [2:0] st, logic [15:0] idx, logic [7:0] cnt);
			edge_result_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result status=%0d index=%0d count=%0d",
					$time, st, idx, cnt);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (st !== e.st) begin
				$display("%0t: status expected %0d actual %0d", $time, e.st, st);
				errors++;
			end
			if (idx !== e.idx) begin
				$display("%0t: map_index expected %0d actual %0d", $time, e.idx, idx);
				errors++;
			end
			if (cnt !== e.cnt) begin
				$display("%0t: count expected %0d actual %0d", $time, e.cnt, cnt);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [2:0]  command = '0;
	logic [31:0] region_start = '0;
	logic [31:0] region_end = '0;
	logic [31:0] name_hash = '0;
	logic        ignore_task = 0;
	logic [31:0] block_start = '0;
	logic [15:0] block_size = '0;
	logic        privileged = 0;
	logic [15:0] read_index = '0;
	logic        out_valid;
	logic        out_stall = 1;
	logic [2:0]  status;
	logic [15:0] map_index;
	logic [7:0]  count;

	coverage_scoreboard sb;
	bit          quiet = 0;
	bit          sending_done = 0;
	bit          hold_request = 0;
	int          hold_cycles = 0;
	logic [31:0] base_addr [8];
	logic [31:0] span [8];

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	edge_coverage_map_update_core dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.command(command), .region_start(region_start), .region_end(region_end),
		.name_hash(name_hash), .ignore_task(ignore_task), .block_start(block_start),
		.block_size(block_size), .privileged(privileged), .read_index(read_index),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.map_index(map_index), .count(count)
	);

	task automatic send(logic [2:0] cmd, logic [31:0] rs, logic [31:0] re, logic [31:0] nh,
			logic ign, logic [31:0] bs, logic [15:0] bsz, logic priv, logic [15:0] ridx);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			gap = $urandom_range(1, 15);
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		command <= cmd;
		region_start <= rs;
		region_end <= re;
		name_hash <= nh;
		ignore_task <= ign;
		block_start <= bs;
		block_size <= bsz;
		privileged <= priv;
		read_index <= ridx;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_transfer(cmd, rs, re, nh, ign, bs, bsz, priv, ridx);
		@(negedge clk);
	endtask

	task automatic set_context(logic [31:0] h, logic ign);
		send(CMD_SET_CONTEXT, $urandom, $urandom, h, ign, $urandom, 16'($urandom),
			1'($urandom), 16'($urandom));
	endtask

	task automatic table_cmd(logic [2:0] cmd);
		send(cmd, $urandom, $urandom, $urandom, 1'($urandom), $urandom, 16'($urandom),
			1'($urandom), 16'($urandom));
	endtask

	task automatic append(logic [31:0] lo, logic [31:0] hi, logic [31:0] h);
		send(CMD_APPEND, lo, hi, h, 1'($urandom), $urandom, 16'($urandom), 1'($urandom),
			16'($urandom));
	endtask

	task automatic run_block(logic [31:0] bs, logic [15:0] bsz, logic priv);
		send(CMD_BLOCK, $urandom, $urandom, $urandom, 1'($urandom), bs, bsz, priv,
			16'($urandom));
	endtask

	task automatic read_map(logic [15:0] ix);
		send(CMD_READ, $urandom, $urandom, $urandom, 1'($urandom), $urandom, 16'($urandom),
			1'($urandom), ix);
	endtask

	task automatic build_table(int n);
		table_cmd(CMD_OPEN);
		for (int i = 0; i < n; i++) begin
			base_addr[i % 8] = $urandom;
			span[i % 8] = $urandom_range(16, 4096);
			if (base_addr[i % 8] > 32'hFFFF_0000) base_addr[i % 8] = 32'h8000_0000;
			append(base_addr[i % 8], base_addr[i % 8] + span[i % 8], $urandom);
		end
		table_cmd(CMD_CLOSE);
	endtask

	task automatic random_item();
		int k;
		int j;
		k = $urandom_range(0, 99);
		j = $urandom_range(0, 7);
		if (k < 60)
			run_block(base_addr[j] + $urandom_range(0, span[j] - 1), 16'($urandom_range(1, 64)),
				$urandom_range(0, 9) == 0);
		else if (k < 70)
			run_block($urandom, 16'($urandom), 1'($urandom));
		else if (k < 80)
			read_map($urandom_range(0, 3) == 0 ? 16'(sb.pending.size()) : 16'($urandom));
		else if (k < 85)
			set_context($urandom, $urandom_range(0, 5) == 0);
		else if (k < 88)
			table_cmd(3'($urandom_range(1, 3)));
		else if (k < 90)
			send(3'($urandom_range(6, 7)), $urandom, $urandom, $urandom, 1'($urandom), $urandom,
				16'($urandom), 1'($urandom), 16'($urandom));
		else
			build_table($urandom_range(1, 8));
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(status, map_index, count);
	end

	always @(negedge clk) begin
		if (hold_request) begin
			out_stall <= 1;
			if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
			else hold_request <= 0;
		end else if (!arst_n || quiet) out_stall <= 0;
		else if ($urandom_range(0, 20) == 0) begin
			hold_request <= 1;
			hold_cycles <= $urandom_range(1, 15);
			out_stall <= 1;
		end else out_stall <= 0;
	end

	initial begin
		sb = new();
		sb.init();
		for (int i = 0; i < 8; i++) begin
			base_addr[i] = 32'h1000 * (i + 1);
			span[i] = 32'h100;
		end
		repeat (5) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		// directed
		run_block(32'h1000, 16'd4, 1'b0);
		table_cmd(CMD_OPEN);
		append(32'h0, 32'h1, 32'h0);
		table_cmd(CMD_CLOSE);
		set_context(32'hFFFF_FFFF, 1'b0);
		table_cmd(CMD_CLOSE);
		table_cmd(CMD_OPEN);
		table_cmd(CMD_OPEN);
		append(32'h0, 32'h10, 32'hFFFF_FFFF);
		append(32'hFFFF_FF00, 32'hFFFF_FFFF, 32'h0);
		append(32'h1000, 32'h1100, 32'h1234_5678);
		table_cmd(CMD_CLOSE);
		run_block(32'h0, 16'hFFFF, 1'b0);
		run_block(32'h5, 16'd1, 1'b0);
		run_block(32'hFFFF_FFFE, 16'd0, 1'b0);
		run_block(32'h1080, 16'd2, 1'b1);
		run_block(32'h8000_0000, 16'd4, 1'b0);
		run_block(32'h1080, 16'd2, 1'b0);
		read_map(16'hFFFF);
		read_map(sb.pending.size() > 0 ? 16'h0 : 16'h1);
		send(3'd6, '0, '0, '0, 1'b0, '0, '0, 1'b0, '0);
		send(3'd7, '1, '1, '1, 1'b1, '1, '1, 1'b1, '1);
		set_context(32'h0, 1'b1);
		run_block(32'h1000, 16'd4, 1'b0);
		table_cmd(CMD_OPEN);
		for (int i = 0; i < REG_N + 1; i++)
			append(32'h1000 * (i + 1), 32'h1000 * (i + 1) + 32'h80, $urandom);
		table_cmd(CMD_CLOSE);
		set_context($urandom, 1'b0);
		run_block(32'h1000 * REG_N + 32'h10, 16'd8, 1'b0);
		for (int i = 0; i < 8; i++) begin
			base_addr[i] = 32'h1000 * (i + 1);
			span[i] = 32'h80;
		end
		// long receiver hold-off while input keeps coming
		hold_cycles = 200;
		hold_request = 1;
		for (int i = 0; i < 12; i++) run_block(base_addr[i % 8] + i, 16'd1, 1'b0);
		for (int i = 0; i < 380; i++) random_item();
		quiet = 1;
		for (int i = 0; i < 40; i++) random_item();
		in_valid <= 0;
		sending_done = 1;
	end

	initial begin
		wait (sending_done);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

	initial begin
		#3000000;
		$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire

[edge_coverage_map_update_core.f]
rtl/core/ecmu_pkg.sv
rtl/core/ecmu_region_table.sv
rtl/core/ecmu_hit_map.sv
rtl/core/edge_coverage_map_update_core.sv
tb/tb_edge_coverage_map_update_core.sv
